FILE: rtl/trace_sample_scaler_with_alarms_core_assert.svh
// assertion macros for the trace sample scaler
`ifndef TRACE_SAMPLE_SCALER_WITH_ALARMS_CORE_ASSERT_SVH
`define TRACE_SAMPLE_SCALER_WITH_ALARMS_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TSSA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define TSSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tssa_pkg.sv
// shared types and constants for the trace sample scaler
package tssa_pkg;

  localparam int TRACE_DEPTH = 512;
  localparam int POS_W       = $clog2(TRACE_DEPTH + 1);
  localparam int LIMIT_W     = 10;
  localparam int CMP_W       = ((POS_W > LIMIT_W) ? POS_W : LIMIT_W) + 1;

  localparam int SAMPLE_W = 32;
  localparam int SHORT_W  = 16;
  localparam int INDEX_W  = 9;
  localparam int STATUS_W = 2;
  localparam int NUM_W    = SAMPLE_W + SHORT_W;
  localparam int CNT_W    = $clog2(NUM_W);

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_LOW_ALARM    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_ALARM   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_OFFSET = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ROW     = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_ROW_SPAN     = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_POINT_LIMIT  = CFG_IDX_W'(7);

  // action codes
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_ACCEPTED = 2'd0,
    STAT_REJECTED = 2'd1,
    STAT_CLEARED  = 2'd2
  } status_t;

endpackage

FILE: rtl/tssa_if.sv
// input and result channel interfaces of the trace sample scaler
interface tssa_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [tssa_pkg::SAMPLE_W-1:0] sample_value;

  modport source (output valid, output action, output sample_value, input ready);
  modport sink (input valid, input action, input sample_value, output ready);
endinterface

interface tssa_out_if;
  logic                          valid;
  logic                          ready;
  logic [tssa_pkg::STATUS_W-1:0] status;
  logic [tssa_pkg::INDEX_W-1:0]  point_index;
  logic [tssa_pkg::SHORT_W-1:0]  point_row;
  logic                          trace_full;
  logic                          enter_low;
  logic                          leave_low;
  logic                          enter_high;
  logic                          leave_high;
  logic                          value_changed;

  modport source (
    output valid, output status, output point_index, output point_row,
    output trace_full, output enter_low, output leave_low, output enter_high,
    output leave_high, output value_changed, input ready
  );
  modport sink (
    input valid, input status, input point_index, input point_row,
    input trace_full, input enter_low, input leave_low, input enter_high,
    input leave_high, input value_changed, output ready
  );
endinterface

FILE: rtl/trace_sample_scaler_with_alarms_core.sv
// trace sample scaler: offset, row mapping by iterative division, alarm edges
// sequence per sample: offset, multiply, 48 divide steps, row, output load; an equal range
//   skips the divide steps, and clear and reject results go straight to the output load
// one transfer at a time: input ready only while idle, so a new sample is taken only after the
//   last result is loaded; a result not yet taken holds the next one in the load state
// reset: synchronous active-low rst_n restores register defaults and clears sequencer, trace and output-valid state
`include "trace_sample_scaler_with_alarms_core_assert.svh"

module trace_sample_scaler_with_alarms_core (
  input  logic                            clk,
  input  logic                            rst_n,
  tssa_in_if.sink                         in_ch,
  tssa_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [tssa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tssa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tssa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OFFSET,
    S_MUL,
    S_DIV,
    S_ROW,
    S_WAIT
  } state_t;

  typedef struct packed {
    status_t              status;
    logic [INDEX_W-1:0]   point_index;
    logic [SHORT_W-1:0]   point_row;
    logic                 trace_full;
    logic                 enter_low;
    logic                 leave_low;
    logic                 enter_high;
    logic                 leave_high;
    logic                 value_changed;
  } result_t;

  // configuration registers
  logic [SAMPLE_W-1:0] range_min_r, range_max_r, low_alarm_r, high_alarm_r;
  logic [SHORT_W-1:0]  value_offset_r, base_row_r, row_span_r;
  logic [LIMIT_W-1:0]  point_limit_r;

  // sequencer and trace state
  state_t              state_r, state_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic                full_r, full_nxt;
  logic [SAMPLE_W-1:0] prev_r, prev_nxt;
  logic                prev_valid_r, prev_valid_nxt;

  // per-sample working registers
  logic [SAMPLE_W-1:0] raw_r, raw_nxt;       // raw sample, then offset sample
  logic [SAMPLE_W-1:0] p_r, p_nxt;           // previous sample snapshot
  logic                pv_r, pv_nxt;         // previous sample was valid
  logic [NUM_W-1:0]    prod_r, prod_nxt;     // dividend, shifted out msb first
  logic [SAMPLE_W-1:0] den_r, den_nxt;
  logic [SAMPLE_W-1:0] rem_r, rem_nxt;
  logic [SHORT_W-1:0]  quot_r, quot_nxt;     // low quotient bits only
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  result_t             res_r, res_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  result_t             out_r, out_nxt;

  logic                in_xfer, out_xfer;
  logic [CMP_W-1:0]    pos_ext, pos_inc;
  logic [SAMPLE_W+1:0] div_diff;
  logic                div_qbit;
  logic [SAMPLE_W-1:0] num_diff;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_xfer    = out_valid_r && out_ch.ready;

  assign pos_ext = CMP_W'(pos_r);
  assign pos_inc = pos_ext + CMP_W'(1);

  // sample distance from range_min, wraps at 32 bits before widening
  assign num_diff = raw_r - range_min_r;

  // shared divide step: trial subtract of the shifted remainder
  assign div_diff = {1'b0, rem_r, prod_r[NUM_W-1]} - {2'b00, den_r};
  assign div_qbit = !div_diff[SAMPLE_W+1];

  // register file writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_min_r    <= '0;
      range_max_r    <= SAMPLE_W'(100);
      low_alarm_r    <= '0;
      high_alarm_r   <= '1;
      value_offset_r <= '0;
      base_row_r     <= '0;
      row_span_r     <= '0;
      point_limit_r  <= LIMIT_W'(512);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RANGE_MIN:    range_min_r    <= cfg_data[SAMPLE_W-1:0];
        REG_RANGE_MAX:    range_max_r    <= cfg_data[SAMPLE_W-1:0];
        REG_LOW_ALARM:    low_alarm_r    <= cfg_data[SAMPLE_W-1:0];
        REG_HIGH_ALARM:   high_alarm_r   <= cfg_data[SAMPLE_W-1:0];
        REG_VALUE_OFFSET: value_offset_r <= cfg_data[SHORT_W-1:0];
        REG_BASE_ROW:     base_row_r     <= cfg_data[SHORT_W-1:0];
        REG_ROW_SPAN:     row_span_r     <= cfg_data[SHORT_W-1:0];
        REG_POINT_LIMIT:  point_limit_r  <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    full_nxt       = full_r;
    prev_nxt       = prev_r;
    prev_valid_nxt = prev_valid_r;
    raw_nxt        = raw_r;
    p_nxt          = p_r;
    pv_nxt         = pv_r;
    prod_nxt       = prod_r;
    den_nxt        = den_r;
    rem_nxt        = rem_r;
    quot_nxt       = quot_r;
    cnt_nxt        = cnt_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;

    if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          res_nxt = '0;
          if (in_ch.action == ACT_CLEAR) begin
            // clear keeps the previous sample for edge detection
            pos_nxt        = '0;
            full_nxt       = 1'b0;
            res_nxt.status = STAT_CLEARED;
            state_nxt      = S_WAIT;
          end else if (pos_ext >= CMP_W'(TRACE_DEPTH)) begin
            // store exhausted, nothing changes
            res_nxt.status     = STAT_REJECTED;
            res_nxt.trace_full = full_r;
            state_nxt          = S_WAIT;
          end else begin
            raw_nxt = in_ch.sample_value;
            p_nxt   = prev_r;
            pv_nxt  = prev_valid_r;
            pos_nxt = pos_inc[POS_W-1:0];
            if (pos_inc > CMP_W'(point_limit_r)) begin
              full_nxt = 1'b1;
            end
            res_nxt.status      = STAT_ACCEPTED;
            res_nxt.point_index = pos_ext[INDEX_W-1:0];
            state_nxt           = S_OFFSET;
          end
        end
      end

      S_OFFSET: begin
        raw_nxt            = raw_r + SAMPLE_W'(value_offset_r);
        res_nxt.trace_full = full_r;
        state_nxt          = S_MUL;
      end

      S_MUL: begin
        prod_nxt       = NUM_W'(num_diff) * NUM_W'(row_span_r);
        den_nxt        = range_max_r - range_min_r;
        rem_nxt        = '0;
        quot_nxt       = '0;
        cnt_nxt        = CNT_W'(NUM_W - 1);
        prev_nxt       = raw_r;
        prev_valid_nxt = 1'b1;
        if (pv_r) begin
          res_nxt.enter_low     = (p_r > low_alarm_r) && (raw_r <= low_alarm_r);
          res_nxt.leave_low     = (p_r <= low_alarm_r) && (raw_r > low_alarm_r);
          res_nxt.enter_high    = (p_r < high_alarm_r) && (raw_r >= high_alarm_r);
          res_nxt.leave_high    = (p_r >= high_alarm_r) && (raw_r < high_alarm_r);
          res_nxt.value_changed = (p_r != raw_r);
        end
        // equal range: quotient stays zero, skip the divider
        if (range_max_r == range_min_r) begin
          state_nxt = S_ROW;
        end else begin
          state_nxt = S_DIV;
        end
      end

      S_DIV: begin
        prod_nxt = {prod_r[NUM_W-2:0], 1'b0};
        quot_nxt = {quot_r[SHORT_W-2:0], div_qbit};
        if (div_qbit) begin
          rem_nxt = div_diff[SAMPLE_W-1:0];
        end else begin
          rem_nxt = {rem_r[SAMPLE_W-2:0], prod_r[NUM_W-1]};
        end
        if (cnt_r == '0) begin
          state_nxt = S_ROW;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end

      S_ROW: begin
        res_nxt.point_row = base_row_r - quot_r;
        state_nxt         = S_WAIT;
      end

      S_WAIT: begin
        // load the output register once it is free or being drained
        if (!out_valid_r || out_ch.ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pos_r        <= '0;
      full_r       <= 1'b0;
      prev_r       <= '0;
      prev_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pos_r        <= pos_nxt;
      full_r       <= full_nxt;
      prev_r       <= prev_nxt;
      prev_valid_r <= prev_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    raw_r  <= raw_nxt;
    p_r    <= p_nxt;
    pv_r   <= pv_nxt;
    prod_r <= prod_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    cnt_r  <= cnt_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_r.status;
  assign out_ch.point_index   = out_r.point_index;
  assign out_ch.point_row     = out_r.point_row;
  assign out_ch.trace_full    = out_r.trace_full;
  assign out_ch.enter_low     = out_r.enter_low;
  assign out_ch.leave_low     = out_r.leave_low;
  assign out_ch.enter_high    = out_r.enter_high;
  assign out_ch.leave_high    = out_r.leave_high;
  assign out_ch.value_changed = out_r.value_changed;

  // a new result only comes from the output load state
  `TSSA_ASSERT_IMPL(a_out_from_wait, clk, rst_n, $rose(out_valid_r),
    $past(state_r == S_WAIT), "result valid rose outside output load")
  // a clear transfer always empties the trace position and full flag
  `TSSA_ASSERT_NEXT(a_clear_resets, clk, rst_n, in_xfer && (in_ch.action == ACT_CLEAR),
    (pos_r == '0) && !full_r, "clear did not reset trace position")
  // the position never runs past the store depth
  `TSSA_ASSERT_IMPL(a_pos_bound, clk, rst_n, 1'b1, pos_ext <= CMP_W'(TRACE_DEPTH),
    "trace position beyond store depth")
  // the divider never runs with a zero divisor
  `TSSA_ASSERT_IMPL(a_div_nonzero, clk, rst_n, state_r == S_DIV, den_r != '0,
    "divide step with zero divisor")
  // a pending result is held until it is taken
  `TSSA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_r && !out_ch.ready,
    out_valid_r && $stable(out_r), "pending result changed before transfer")

endmodule

FILE: dv/tssa_trace_checker.sv
// scoreboard for the trace sample scaler: predicts each result and compares it
module tssa_trace_checker
  import tssa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  tssa_in_if                    in_ch,
  tssa_out_if                   out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending_count
);

  typedef struct packed {
    status_t                   status;
    logic [INDEX_W-1:0]        point_index;
    logic [SHORT_W-1:0]        point_row;
    logic                      trace_full;
    logic                      enter_low;
    logic                      leave_low;
    logic                      enter_high;
    logic                      leave_high;
    logic                      value_changed;
  } trace_result_t;

  // register copies
  logic [SAMPLE_W-1:0] range_min, range_max, low_alarm, high_alarm;
  logic [SHORT_W-1:0]  value_offset, base_row, row_span;
  logic [LIMIT_W-1:0]  point_limit;

  // trace state
  logic [POS_W-1:0]    write_pos;
  logic                full_flag;
  logic [SAMPLE_W-1:0] prev_value;
  logic                prev_valid;

  trace_result_t       rows_due[$];

  // exact 48-bit product, quotient forced to zero on an equal range
  function automatic logic [SHORT_W-1:0] plot_row(input logic [SAMPLE_W-1:0] v);
    logic [SAMPLE_W-1:0] num;
    logic [SAMPLE_W-1:0] den;
    logic [63:0]         quot;
    num  = v - range_min;
    den  = range_max - range_min;
    quot = (den != '0) ? (64'(num) * 64'(row_span)) / 64'(den) : 64'd0;
    return base_row - quot[SHORT_W-1:0];
  endfunction

  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_RANGE_MIN:    range_min    = data;
      REG_RANGE_MAX:    range_max    = data;
      REG_LOW_ALARM:    low_alarm    = data;
      REG_HIGH_ALARM:   high_alarm   = data;
      REG_VALUE_OFFSET: value_offset = data[SHORT_W-1:0];
      REG_BASE_ROW:     base_row     = data[SHORT_W-1:0];
      REG_ROW_SPAN:     row_span     = data[SHORT_W-1:0];
      REG_POINT_LIMIT:  point_limit  = data[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic predict_row(input logic act, input logic [SAMPLE_W-1:0] raw);
    trace_result_t       r;
    logic [SAMPLE_W-1:0] v;
    r = '0;
    if (act == ACT_CLEAR) begin
      write_pos = '0;
      full_flag = 1'b0;
      r.status  = STAT_CLEARED;
    end else if (write_pos >= TRACE_DEPTH) begin
      // store exhausted: nothing moves
      r.status     = STAT_REJECTED;
      r.trace_full = full_flag;
    end else begin
      v             = raw + SAMPLE_W'(value_offset);
      r.status      = STAT_ACCEPTED;
      r.point_index = write_pos[INDEX_W-1:0];
      r.point_row   = plot_row(v);
      write_pos     = write_pos + 1'b1;
      if (write_pos > point_limit) full_flag = 1'b1;
      r.trace_full  = full_flag;
      if (prev_valid) begin
        r.enter_low     = (prev_value > low_alarm) && (v <= low_alarm);
        r.leave_low     = (prev_value <= low_alarm) && (v > low_alarm);
        r.enter_high    = (prev_value < high_alarm) && (v >= high_alarm);
        r.leave_high    = (prev_value >= high_alarm) && (v < high_alarm);
        r.value_changed = (prev_value != v);
      end
      prev_value = v;
      prev_valid = 1'b1;
    end
    rows_due.push_back(r);
  endtask

  task automatic match_field(input string what, input logic [63:0] want, input logic [63:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, seen);
      fail_count++;
    end
  endtask

  task automatic check_row();
    trace_result_t want;
    if (rows_due.size() == 0) begin
      $display("%0t: result with nothing outstanding, expected none actual status %0h",
               $time, out_ch.status);
      fail_count++;
    end else begin
      want = rows_due.pop_front();
      match_field("status",        64'(want.status),        64'(out_ch.status));
      match_field("point_index",   64'(want.point_index),   64'(out_ch.point_index));
      match_field("point_row",     64'(want.point_row),     64'(out_ch.point_row));
      match_field("trace_full",    64'(want.trace_full),    64'(out_ch.trace_full));
      match_field("enter_low",     64'(want.enter_low),     64'(out_ch.enter_low));
      match_field("leave_low",     64'(want.leave_low),     64'(out_ch.leave_low));
      match_field("enter_high",    64'(want.enter_high),    64'(out_ch.enter_high));
      match_field("leave_high",    64'(want.leave_high),    64'(out_ch.leave_high));
      match_field("value_changed", 64'(want.value_changed), 64'(out_ch.value_changed));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      range_min    = '0;
      range_max    = SAMPLE_W'(100);
      low_alarm    = '0;
      high_alarm   = '1;
      value_offset = '0;
      base_row     = '0;
      row_span     = '0;
      point_limit  = LIMIT_W'(TRACE_DEPTH);
      write_pos    = '0;
      full_flag    = 1'b0;
      prev_value   = '0;
      prev_valid   = 1'b0;
      fail_count   = 0;
      rows_due.delete();
    end else begin
      if (cfg_we) apply_write(cfg_index, cfg_data);
      if (in_ch.valid && in_ch.ready) predict_row(in_ch.action, in_ch.sample_value);
      if (out_ch.valid && out_ch.ready) check_row();
    end
    pending_count <= rows_due.size();
  end

endmodule

FILE: dv/tb_trace_sample_scaler_with_alarms_core.sv
// testbench top for the trace sample scaler: stimulus, idling and verdict
module tb_trace_sample_scaler_with_alarms_core;
  import tssa_pkg::*;

  localparam int RANDOM_ITEMS = 2000;
  localparam int QUIET_TAIL   = 200;      // last items run with no idling
  localparam int DRAIN_CYCLES = 64;       // longer than the sample latency
  localparam int CYCLE_LIMIT  = 1000000;  // watchdog limit in cycles

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = CFG_IDX_W'(8);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = CFG_IDX_W'(15);

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tssa_in_if  in_ch ();
  tssa_out_if out_ch ();

  int fail_count;
  int pending_count;
  int cycle_count = 0;

  // idling switch shared by the sender and the result stall process
  logic idle_on = 1'b1;

  // stimulus-side copies of registers, used to aim samples and to set an equal range
  logic [SAMPLE_W-1:0] aim_range_min  = '0;
  logic [SAMPLE_W-1:0] aim_range_max  = SAMPLE_W'(100);
  logic [SAMPLE_W-1:0] aim_low_alarm  = '0;
  logic [SAMPLE_W-1:0] aim_high_alarm = '1;
  logic [SHORT_W-1:0]  aim_offset     = '0;
  logic [SAMPLE_W-1:0] last_aim       = '0;

  int n_samples    = 0;
  int n_clears     = 0;
  int n_writes     = 0;
  int n_fill_runs  = 0;
  int random_sent  = 0;

  always #6 clk = ~clk;

  trace_sample_scaler_with_alarms_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tssa_trace_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_count);
      $display("FAILURE");
      $finish;
    end
  end

  // result side backpressure: random stall bursts between ready stretches while idling is on
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // one input transfer; an idle burst may come first, otherwise valid stays high
  task automatic send_item(input logic act, input logic [SAMPLE_W-1:0] raw);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= act;
    in_ch.sample_value <= raw;
    do @(posedge clk); while (!in_ch.ready);
    if (act == ACT_CLEAR) n_clears++;
    else n_samples++;
  endtask

  // wait for every outstanding result; pending count is registered, so it lags the checker queue
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // single register write, with cfg_we dropped again before the task returns
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    n_writes++;
    case (idx)
      REG_RANGE_MIN:    aim_range_min  = data;
      REG_RANGE_MAX:    aim_range_max  = data;
      REG_LOW_ALARM:    aim_low_alarm  = data;
      REG_HIGH_ALARM:   aim_high_alarm = data;
      REG_VALUE_OFFSET: aim_offset     = data[SHORT_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [SAMPLE_W-1:0] wide_pick();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return SAMPLE_W'($urandom_range(0, 300));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] short_pick();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return CFG_DATA_W'(16'hFFFF);
      2:       return CFG_DATA_W'($urandom_range(0, 600));
      default: return CFG_DATA_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // raw sample aimed at an interesting offset value: thresholds, range ends, repeats
  function automatic logic [SAMPLE_W-1:0] next_raw();
    logic [SAMPLE_W-1:0] aim;
    case ($urandom_range(0, 9))
      0, 1, 2: aim = $urandom();
      3:       aim = aim_low_alarm + SAMPLE_W'($urandom_range(0, 2)) - 1'b1;
      4:       aim = aim_high_alarm + SAMPLE_W'($urandom_range(0, 2)) - 1'b1;
      5:       aim = aim_range_min + SAMPLE_W'($urandom_range(0, 4)) - 2'd2;
      6:       aim = aim_range_max + SAMPLE_W'($urandom_range(0, 4)) - 2'd2;
      7:       aim = last_aim;
      8:       aim = $urandom_range(0, 1) ? '1 : '0;
      default: aim = SAMPLE_W'($urandom_range(0, 255));
    endcase
    last_aim = aim;
    return aim - SAMPLE_W'(aim_offset);
  endfunction

  // new random setting for part of the registers, extremes weighted in
  task automatic shuffle_config();
    if ($urandom_range(0, 1)) write_reg(REG_RANGE_MIN, wide_pick());
    if ($urandom_range(0, 5) == 0)
      write_reg(REG_RANGE_MAX, aim_range_min);                 // equal range
    else if ($urandom_range(0, 2) == 0)
      write_reg(REG_RANGE_MAX, aim_range_min + SAMPLE_W'($urandom_range(1, 1000)));
    else if ($urandom_range(0, 1))
      write_reg(REG_RANGE_MAX, wide_pick());
    if ($urandom_range(0, 1)) write_reg(REG_LOW_ALARM, wide_pick());
    if ($urandom_range(0, 1)) write_reg(REG_HIGH_ALARM, wide_pick());
    if ($urandom_range(0, 2) == 0) write_reg(REG_VALUE_OFFSET, short_pick());
    if ($urandom_range(0, 1)) write_reg(REG_BASE_ROW, short_pick());
    if ($urandom_range(0, 1)) write_reg(REG_ROW_SPAN, short_pick());
    if ($urandom_range(0, 2) == 0) begin
      case ($urandom_range(0, 3))
        0:       write_reg(REG_POINT_LIMIT, '0);
        1:       write_reg(REG_POINT_LIMIT, CFG_DATA_W'(TRACE_DEPTH));
        2:       write_reg(REG_POINT_LIMIT, CFG_DATA_W'($urandom_range(0, 20)));
        default: write_reg(REG_POINT_LIMIT, CFG_DATA_W'($urandom_range(0, TRACE_DEPTH)));
      endcase
    end
    // stray writes to unmapped indexes must change nothing
    if ($urandom_range(0, 11) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_FIRST : REG_SPARE_LAST, $urandom());
  endtask

  initial begin
    int burst;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= '0;
    cfg_data           <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.action       <= ACT_SAMPLE;
    in_ch.sample_value <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: first sample has no edges, then high and low alarm crossings
    send_item(ACT_SAMPLE, 32'h0000_0000);
    send_item(ACT_SAMPLE, 32'h0000_0000);          // unchanged value
    send_item(ACT_SAMPLE, 32'hFFFF_FFFF);          // enters high alarm
    send_item(ACT_SAMPLE, 32'd50);                 // leaves high alarm
    send_item(ACT_CLEAR,  32'hA5A5_A5A5);          // clear keeps previous sample
    send_item(ACT_SAMPLE, 32'h0000_0000);          // enters low alarm
    send_item(ACT_SAMPLE, 32'd1);                  // leaves low alarm

    // full-width range and span, small point limit so the full flag sets
    wait_idle();
    write_reg(REG_RANGE_MIN, '0);
    write_reg(REG_RANGE_MAX, '1);
    write_reg(REG_ROW_SPAN, CFG_DATA_W'(16'hFFFF));
    write_reg(REG_BASE_ROW, CFG_DATA_W'(16'hFFFF));
    write_reg(REG_POINT_LIMIT, CFG_DATA_W'(2));
    send_item(ACT_SAMPLE, 32'hFFFF_FFFF);          // largest product; passes the point limit
    send_item(ACT_SAMPLE, 32'h0000_0000);
    send_item(ACT_SAMPLE, 32'h8000_0000);          // mid-range value, full flag stays set

    // equal range, offset wrapping past 2^32, thresholds one apart, unmapped writes
    wait_idle();
    write_reg(REG_RANGE_MIN, 32'h1234_5678);
    write_reg(REG_RANGE_MAX, 32'h1234_5678);
    write_reg(REG_VALUE_OFFSET, CFG_DATA_W'(16'hFFFF));
    write_reg(REG_LOW_ALARM, 32'h0000_FFFF);
    write_reg(REG_HIGH_ALARM, 32'h0001_0000);
    write_reg(REG_POINT_LIMIT, '0);
    write_reg(REG_SPARE_FIRST, '1);
    write_reg(REG_SPARE_LAST, 32'h0000_0000);
    send_item(ACT_SAMPLE, 32'hFFFF_0001);          // offset sum wraps to zero
    send_item(ACT_SAMPLE, 32'h0000_0000);          // exactly on the low alarm
    send_item(ACT_SAMPLE, 32'h0000_0001);          // low to high in one step
    send_item(ACT_SAMPLE, 32'hFFFF_FFFF);
    send_item(ACT_CLEAR,  32'h0000_0000);

    // inverted range: both differences wrap
    wait_idle();
    write_reg(REG_RANGE_MIN, 32'd1000);
    write_reg(REG_RANGE_MAX, 32'd10);
    write_reg(REG_BASE_ROW, '0);
    write_reg(REG_ROW_SPAN, CFG_DATA_W'(37));
    write_reg(REG_VALUE_OFFSET, '0);
    write_reg(REG_POINT_LIMIT, CFG_DATA_W'(TRACE_DEPTH));
    send_item(ACT_SAMPLE, 32'd999);
    send_item(ACT_SAMPLE, 32'd5);
    send_item(ACT_SAMPLE, 32'd1000);

    // random phases: each one a new setting and a burst of transfers
    while (random_sent < RANDOM_ITEMS) begin
      wait_idle();
      shuffle_config();
      if (random_sent >= RANDOM_ITEMS - QUIET_TAIL) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 5) != 0);

      if ((n_fill_runs == 0 && random_sent >= 100) ||
          (n_fill_runs == 1 && random_sent >= 1000)) begin
        // fill every store slot, then push a few more to see them rejected
        send_item(ACT_CLEAR, $urandom());
        repeat (TRACE_DEPTH + $urandom_range(3, 12)) send_item(ACT_SAMPLE, next_raw());
        send_item(ACT_CLEAR, $urandom());
        random_sent += TRACE_DEPTH + 8;
        n_fill_runs++;
      end else begin
        burst = $urandom_range(1, 48);
        repeat (burst) begin
          if ($urandom_range(0, 19) == 0) send_item(ACT_CLEAR, $urandom());
          else send_item(ACT_SAMPLE, next_raw());
        end
        random_sent += burst;
      end
    end

    // drain and let any stray result show up
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d samples and %0d clears, %0d register writes, %0d store overflow runs",
             n_samples, n_clears, n_writes, n_fill_runs);
    $display("mismatches seen: %0d, cycles used: %0d", fail_count, cycle_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/tssa_pkg.sv
rtl/tssa_if.sv
rtl/trace_sample_scaler_with_alarms_core.sv
dv/tssa_trace_checker.sv
dv/tb_trace_sample_scaler_with_alarms_core.sv
